### rtl/cmfs_pkg.sv
// shared widths, face codes and divider stage data for the cube map face select core
package cmfs_pkg;

  localparam int COMP_BITS  = 16;
  localparam int COORD_BITS = 17;
  localparam int FACE_BITS  = 3;

  typedef logic signed [COMP_BITS-1:0] comp_t;
  typedef logic        [COMP_BITS-1:0] mag_t;
  typedef logic signed [COMP_BITS:0]   ext_t;
  typedef logic        [COMP_BITS:0]   rem_t;
  typedef logic        [COORD_BITS-1:0] coord_t;

  typedef enum logic [FACE_BITS-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic   nz;
    face_t  face;
    rem_t   div;
    rem_t   rs;
    rem_t   rt;
    coord_t qs;
    coord_t qt;
  } div_data_t;

endpackage

### rtl/cmfs_div.sv
// pipelined restoring divider, one quotient bit per stage for both face coordinates
module cmfs_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  cmfs_pkg::div_data_t in_data,
  output logic                out_vld,
  output cmfs_pkg::div_data_t out_data
);

  localparam int STAGES = cmfs_pkg::COORD_BITS;

  logic [STAGES-1:0]   vld;
  cmfs_pkg::div_data_t stage [STAGES];

  function automatic cmfs_pkg::div_data_t div_step(input cmfs_pkg::div_data_t a);
    cmfs_pkg::div_data_t b;
    logic                ge_s;
    logic                ge_t;
    cmfs_pkg::rem_t      ds;
    cmfs_pkg::rem_t      dt;
    b    = a;
    ge_s = (a.rs >= a.div);
    ge_t = (a.rt >= a.div);
    ds   = ge_s ? (a.rs - a.div) : a.rs;
    dt   = ge_t ? (a.rt - a.div) : a.rt;
    b.rs = {ds[cmfs_pkg::COMP_BITS-1:0], 1'b0};
    b.rt = {dt[cmfs_pkg::COMP_BITS-1:0], 1'b0};
    b.qs = {a.qs[cmfs_pkg::COORD_BITS-2:0], ge_s};
    b.qt = {a.qt[cmfs_pkg::COORD_BITS-2:0], ge_t};
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    stage[0] <= div_step(in_data);
    for (int i = 1; i < STAGES; i++) begin
      stage[i] <= div_step(stage[i-1]);
    end
  end

  assign out_vld  = vld[STAGES-1];
  assign out_data = stage[STAGES-1];

endmodule

### rtl/cube_map_face_select_core.sv
// cube map face select core: major axis face pick and pipelined face coordinate division
// A new item is taken in every cycle (busy stays low). Its result reaches the ports with done
// high after passing through one input register, one major axis stage, one numerator stage,
// 17 divider stages of one quotient bit each, and one output register. Results come one per
// cycle in input order and cannot be held off. The zero vector gives valid_res low with face,
// coord_s and coord_t zero.
module cube_map_face_select_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  cmfs_pkg::comp_t                  dir_x,
  input  cmfs_pkg::comp_t                  dir_y,
  input  cmfs_pkg::comp_t                  dir_z,
  output logic                             done,
  output logic [cmfs_pkg::FACE_BITS-1:0]   face,
  output logic [cmfs_pkg::COORD_BITS-1:0]  coord_s,
  output logic [cmfs_pkg::COORD_BITS-1:0]  coord_t,
  output logic                             valid_res
);

  localparam int N = cmfs_pkg::COMP_BITS;

  // input register
  logic            s1_vld;
  cmfs_pkg::comp_t s1_x;
  cmfs_pkg::comp_t s1_y;
  cmfs_pkg::comp_t s1_z;

  // major axis stage
  logic            s2_vld;
  cmfs_pkg::face_t s2_face;
  cmfs_pkg::ext_t  s2_sc;
  cmfs_pkg::ext_t  s2_tc;
  cmfs_pkg::mag_t  s2_rc;

  // divider input
  logic                div_vld;
  cmfs_pkg::div_data_t div_in;
  logic                res_vld;
  cmfs_pkg::div_data_t res;

  cmfs_pkg::mag_t  ax;
  cmfs_pkg::mag_t  ay;
  cmfs_pkg::mag_t  az;
  cmfs_pkg::ext_t  ex;
  cmfs_pkg::ext_t  ey;
  cmfs_pkg::ext_t  ez;
  cmfs_pkg::face_t face_next;
  cmfs_pkg::ext_t  sc_next;
  cmfs_pkg::ext_t  tc_next;
  cmfs_pkg::mag_t  rc_next;
  cmfs_pkg::rem_t  num_s;
  cmfs_pkg::rem_t  num_t;

  assign busy = 1'b0;

  always_comb begin
    ax = s1_x[N-1] ? cmfs_pkg::mag_t'(-s1_x) : cmfs_pkg::mag_t'(s1_x);
    ay = s1_y[N-1] ? cmfs_pkg::mag_t'(-s1_y) : cmfs_pkg::mag_t'(s1_y);
    az = s1_z[N-1] ? cmfs_pkg::mag_t'(-s1_z) : cmfs_pkg::mag_t'(s1_z);
    ex = cmfs_pkg::ext_t'(s1_x);
    ey = cmfs_pkg::ext_t'(s1_y);
    ez = cmfs_pkg::ext_t'(s1_z);
    priority if (ax > ay && ax > az) begin
      rc_next = ax;
      tc_next = -ey;
      if (!s1_x[N-1] && s1_x != '0) begin
        face_next = cmfs_pkg::FACE_POS_X;
        sc_next   = -ez;
      end else begin
        face_next = cmfs_pkg::FACE_NEG_X;
        sc_next   = ez;
      end
    end else if (ay >= ax && ay > az) begin
      rc_next = ay;
      sc_next = ex;
      if (!s1_y[N-1] && s1_y != '0) begin
        face_next = cmfs_pkg::FACE_POS_Y;
        tc_next   = ez;
      end else begin
        face_next = cmfs_pkg::FACE_NEG_Y;
        tc_next   = -ez;
      end
    end else begin
      rc_next = az;
      tc_next = -ey;
      if (!s1_z[N-1] && s1_z != '0) begin
        face_next = cmfs_pkg::FACE_POS_Z;
        sc_next   = ex;
      end else begin
        face_next = cmfs_pkg::FACE_NEG_Z;
        sc_next   = -ex;
      end
    end
  end

  // numerators lie in 0 .. 2*rc, so the wrapped sum is exact
  assign num_s = cmfs_pkg::rem_t'({1'b0, s2_rc} + s2_sc);
  assign num_t = cmfs_pkg::rem_t'({1'b0, s2_rc} + s2_tc);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      div_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      s1_vld  <= start && !busy;
      s2_vld  <= s1_vld;
      div_vld <= s2_vld;
      done    <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_x        <= dir_x;
    s1_y        <= dir_y;
    s1_z        <= dir_z;
    s2_face     <= face_next;
    s2_sc       <= sc_next;
    s2_tc       <= tc_next;
    s2_rc       <= rc_next;
    div_in.nz   <= (s2_rc != '0);
    div_in.face <= s2_face;
    div_in.div  <= {s2_rc, 1'b0};
    div_in.rs   <= num_s;
    div_in.rt   <= num_t;
    div_in.qs   <= '0;
    div_in.qt   <= '0;
    face        <= res.nz ? res.face : cmfs_pkg::FACE_POS_X;
    coord_s     <= res.nz ? res.qs : '0;
    coord_t     <= res.nz ? res.qt : '0;
    valid_res   <= res.nz;
  end

  cmfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (div_vld),
    .in_data  (div_in),
    .out_vld  (res_vld),
    .out_data (res)
  );

endmodule

### tb/tb_cube_map_face_select_core.sv
// testbench for the cube map face select core: directed and random directions vs a predictor
module tb_cube_map_face_select_core;

  typedef struct {
    cmfs_pkg::comp_t x;
    cmfs_pkg::comp_t y;
    cmfs_pkg::comp_t z;
    bit              drain;
  } dir_item_t;

  typedef struct {
    cmfs_pkg::face_t  face;
    cmfs_pkg::coord_t s;
    cmfs_pkg::coord_t t;
    logic             valid;
  } face_result_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  cmfs_pkg::comp_t  dir_x = '0;
  cmfs_pkg::comp_t  dir_y = '0;
  cmfs_pkg::comp_t  dir_z = '0;
  logic   done;
  logic [cmfs_pkg::FACE_BITS-1:0]  face;
  logic [cmfs_pkg::COORD_BITS-1:0] coord_s;
  logic [cmfs_pkg::COORD_BITS-1:0] coord_t;
  logic   valid_res;

  dir_item_t    dir_queue[$];
  face_result_t pending_faces[$];
  logic         item_taken = 1'b0;
  int           idle_left = 0;
  bit           burst = 1'b0;
  int           err_count = 0;
  int           items_sent = 0;
  int           results_checked = 0;
  int           zero_hits = 0;
  int           face_hits[6];

  cube_map_face_select_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .done      (done),
    .face      (face),
    .coord_s   (coord_s),
    .coord_t   (coord_t),
    .valid_res (valid_res)
  );

  always #6 clk = ~clk;

  function automatic face_result_t predict_face(cmfs_pkg::comp_t x, cmfs_pkg::comp_t y,
                                                cmfs_pkg::comp_t z);
    longint sx, sy, sz, ax, ay, az, sc, tc, rc;
    face_result_t r;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    if (ax > ay && ax > az) begin
      rc = ax;
      tc = -sy;
      if (sx > 0) begin
        r.face = cmfs_pkg::FACE_POS_X;
        sc = -sz;
      end else begin
        r.face = cmfs_pkg::FACE_NEG_X;
        sc = sz;
      end
    end else if (ay >= ax && ay > az) begin
      rc = ay;
      sc = sx;
      if (sy > 0) begin
        r.face = cmfs_pkg::FACE_POS_Y;
        tc = sz;
      end else begin
        r.face = cmfs_pkg::FACE_NEG_Y;
        tc = -sz;
      end
    end else begin
      rc = az;
      tc = -sy;
      if (sz > 0) begin
        r.face = cmfs_pkg::FACE_POS_Z;
        sc = sx;
      end else begin
        r.face = cmfs_pkg::FACE_NEG_Z;
        sc = -sx;
      end
    end
    if (rc == 0) begin
      r.face  = cmfs_pkg::FACE_POS_X;
      r.s     = '0;
      r.t     = '0;
      r.valid = 1'b0;
    end else begin
      r.s     = cmfs_pkg::coord_t'(((rc + sc) * 32768) / rc);
      r.t     = cmfs_pkg::coord_t'(((rc + tc) * 32768) / rc);
      r.valid = 1'b1;
    end
    return r;
  endfunction

  function automatic cmfs_pkg::comp_t signed_mag(int m);
    return ($urandom_range(0, 1) != 0) ? cmfs_pkg::comp_t'(-m) : cmfs_pkg::comp_t'(m);
  endfunction

  function automatic cmfs_pkg::comp_t edge_value();
    case ($urandom_range(0, 6))
      0: return cmfs_pkg::comp_t'(-32768);
      1: return cmfs_pkg::comp_t'(-32767);
      2: return cmfs_pkg::comp_t'(-1);
      3: return cmfs_pkg::comp_t'(0);
      4: return cmfs_pkg::comp_t'(1);
      5: return cmfs_pkg::comp_t'(32766);
      default: return cmfs_pkg::comp_t'(32767);
    endcase
  endfunction

  task automatic queue_dir(int x, int y, int z, bit drain);
    dir_item_t it;
    it.x = cmfs_pkg::comp_t'(x);
    it.y = cmfs_pkg::comp_t'(y);
    it.z = cmfs_pkg::comp_t'(z);
    it.drain = drain;
    dir_queue.push_back(it);
  endtask

  // driver
  always @(negedge clk) begin : drive
    dir_item_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !item_taken)) begin
      if (idle_left > 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
        dir_x <= cmfs_pkg::comp_t'($urandom);
        dir_y <= cmfs_pkg::comp_t'($urandom);
        dir_z <= cmfs_pkg::comp_t'($urandom);
      end else if (dir_queue.size() != 0 &&
                   !(dir_queue[0].drain && pending_faces.size() != 0)) begin
        nxt = dir_queue.pop_front();
        dir_x <= nxt.x;
        dir_y <= nxt.y;
        dir_z <= nxt.z;
        start <= 1'b1;
        if ($urandom_range(0, 39) == 0) burst = !burst;
        idle_left = burst ? 0 : $urandom_range(0, 8);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : check
    face_result_t exp_r;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      if (done) begin
        if (pending_faces.size() == 0) begin
          err_count = err_count + 1;
          $display("%0t: result with no item waiting: face %0d s %0d t %0d valid %0b",
                   $time, face, coord_s, coord_t, valid_res);
        end else begin
          exp_r = pending_faces.pop_front();
          results_checked = results_checked + 1;
          if (exp_r.valid) face_hits[exp_r.face] = face_hits[exp_r.face] + 1;
          else zero_hits = zero_hits + 1;
          if (face !== exp_r.face) begin
            err_count = err_count + 1;
            $display("%0t: face mismatch: expected %0d actual %0d", $time, exp_r.face, face);
          end
          if (coord_s !== exp_r.s) begin
            err_count = err_count + 1;
            $display("%0t: coord_s mismatch: expected %0d actual %0d", $time, exp_r.s, coord_s);
          end
          if (coord_t !== exp_r.t) begin
            err_count = err_count + 1;
            $display("%0t: coord_t mismatch: expected %0d actual %0d", $time, exp_r.t, coord_t);
          end
          if (valid_res !== exp_r.valid) begin
            err_count = err_count + 1;
            $display("%0t: valid_res mismatch: expected %0b actual %0b", $time, exp_r.valid,
                     valid_res);
          end
        end
      end
      if (start && !busy) begin
        pending_faces.push_back(predict_face(dir_x, dir_y, dir_z));
        items_sent = items_sent + 1;
      end
      item_taken <= start && !busy;
    end
  end

  initial begin
    #1200000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int cat, m, ax;
    cmfs_pkg::comp_t v[3];
    for (int i = 0; i < 6; i++) face_hits[i] = 0;

    // directed
    queue_dir(0, 0, 0, 1'b0);
    queue_dir(1000, 10, -20, 1'b0);
    queue_dir(-1000, 10, -20, 1'b0);
    queue_dir(30, 2000, -400, 1'b0);
    queue_dir(30, -2000, -400, 1'b0);
    queue_dir(-7, 3, 900, 1'b0);
    queue_dir(-7, 3, -900, 1'b0);
    queue_dir(-32768, 0, 0, 1'b0);
    queue_dir(32767, -32768, 5, 1'b0);
    queue_dir(0, 0, -32768, 1'b0);
    queue_dir(-32768, -32768, -32768, 1'b0);
    queue_dir(32767, 32767, 32767, 1'b0);
    queue_dir(500, -500, 20, 1'b0);
    queue_dir(-500, 100, 500, 1'b0);
    queue_dir(9, 300, -300, 1'b0);
    queue_dir(50, 0, 50, 1'b0);
    queue_dir(-50, 0, 50, 1'b0);
    queue_dir(1, 0, 0, 1'b0);
    queue_dir(0, -1, 0, 1'b0);
    queue_dir(0, 0, 1, 1'b0);
    queue_dir(-1, 1, -1, 1'b0);
    queue_dir(32767, -32767, 32767, 1'b0);
    queue_dir(-32768, 32767, -32767, 1'b0);
    queue_dir(12345, -23456, 32767, 1'b0);

    // random
    for (int i = 0; i < 1350; i++) begin
      cat = $urandom_range(0, 9);
      if (cat < 4) begin
        v[0] = cmfs_pkg::comp_t'($urandom);
        v[1] = cmfs_pkg::comp_t'($urandom);
        v[2] = cmfs_pkg::comp_t'($urandom);
      end else if (cat < 6) begin
        for (int k = 0; k < 3; k++) v[k] = cmfs_pkg::comp_t'($urandom_range(0, 16) - 8);
      end else if (cat < 8) begin
        // two or three components of equal magnitude
        m = $urandom_range(0, 32767);
        for (int k = 0; k < 3; k++) v[k] = signed_mag(m);
        ax = $urandom_range(0, 3);
        if (ax < 3) v[ax] = signed_mag($urandom_range(0, m));
      end else if (cat == 8) begin
        for (int k = 0; k < 3; k++) v[k] = edge_value();
      end else begin
        m = $urandom_range(1, 32768);
        ax = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) v[k] = signed_mag($urandom_range(0, m - 1));
        v[ax] = (m == 32768) ? cmfs_pkg::comp_t'(-32768) : signed_mag(m);
      end
      queue_dir(v[0], v[1], v[2], (i % 300) == 0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (dir_queue.size() != 0 || start || pending_faces.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("run covered %0d items and %0d checked results, %0d of them zero vectors",
             items_sent, results_checked, zero_hits);
    $display("face hits +x %0d -x %0d +y %0d -y %0d +z %0d -z %0d", face_hits[0],
             face_hits[1], face_hits[2], face_hits[3], face_hits[4], face_hits[5]);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
